@@ sv/pgalloc_pkg.sv @@
// ----------------------------------------------------------------------------
// pgalloc_pkg
// Shared types and constants of the page allocator: field widths, request
// and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pgalloc_pkg;

	// default pool geometry
	localparam int DEF_NUM_PAGES  = 1024;
	localparam int DEF_PAGE_BYTES = 4096;

	// field widths
	localparam int ADDR_W  = 40;
	localparam int MODE_W  = 3;
	localparam int DELTA_W = 9;
	localparam int REF_W   = 8;
	localparam int FREE_W  = 11;
	localparam int STAT_W  = 3;

	localparam logic [REF_W-1:0]  REF_MAX    = 8'd255;
	localparam logic [ADDR_W-1:0] BASE_RESET = 40'h00_8000_0000;

	// request codes
	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 3'd0,
		MODE_FREE  = 3'd1,
		MODE_ADD   = 3'd2,
		MODE_SET   = 3'd3,
		MODE_READ  = 3'd4
	} mode_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_MEM     = 3'd1,
		ST_BAD_ADDR   = 3'd2,
		ST_HEAD_FREE  = 3'd3,
		ST_ZERO_FREE  = 3'd4,
		ST_OVERFLOW   = 3'd5,
		ST_UNDERFLOW  = 3'd6,
		ST_IGNORED    = 3'd7
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;   // capture request, launch memory read
		logic commit;   // write back state and load result
		logic clear;    // initialization sweep write
	} pga_cmd_t;

endpackage

`default_nettype wire

@@ sv/pgalloc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pgalloc_ctrl
// Controller: runs the memory initialization sweep after reset, then steps
// each request through read and execute cycles and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pgalloc_ctrl #(
	parameter int NUM_PAGES = pgalloc_pkg::DEF_NUM_PAGES,
	localparam int IDX_W = $clog2(NUM_PAGES)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pgalloc_pkg::pga_cmd_t     cmd,
	output logic [IDX_W-1:0]          clear_idx
);
	import pgalloc_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

	state_t           state_q;
	logic             in_ready_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             accept;
	logic             commit;

	// handshake decode
	assign accept = in_valid && in_ready_q;
	assign commit = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	// state, sweep counter and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
			clr_cnt_q   <= '0;
		end else begin
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == LAST_IDX) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready     = in_ready_q;
	assign out_valid    = out_valid_q;
	assign cmd.accept   = accept;
	assign cmd.commit   = commit;
	assign cmd.clear    = (state_q == S_CLEAR);
	assign clear_idx    = clr_cnt_q;

endmodule

`default_nettype wire

@@ sv/pgalloc_dp.sv @@
// ----------------------------------------------------------------------------
// pgalloc_dp
// Datapath: address decode, link and count memories, list head and free
// counter, request execution and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pgalloc_dp #(
	parameter int NUM_PAGES  = pgalloc_pkg::DEF_NUM_PAGES,
	parameter int PAGE_BYTES = pgalloc_pkg::DEF_PAGE_BYTES,
	localparam int IDX_W = $clog2(NUM_PAGES)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pgalloc_pkg::pga_cmd_t             cmd,
	input  wire logic [IDX_W-1:0]                  clear_idx,
	input  wire logic                              cfg_wr_en,
	input  wire logic [pgalloc_pkg::ADDR_W-1:0]    cfg_wr_data,
	input  wire logic [pgalloc_pkg::MODE_W-1:0]    mode,
	input  wire logic [pgalloc_pkg::ADDR_W-1:0]    address,
	input  wire logic signed [pgalloc_pkg::DELTA_W-1:0] delta,
	input  wire logic [pgalloc_pkg::REF_W-1:0]     count_value,
	output logic [pgalloc_pkg::ADDR_W-1:0]         page_address,
	output logic [pgalloc_pkg::REF_W-1:0]          ref_count,
	output logic [pgalloc_pkg::FREE_W-1:0]         free_pages,
	output logic [pgalloc_pkg::STAT_W-1:0]         status
);
	import pgalloc_pkg::*;

	localparam int CNT_W = $clog2(NUM_PAGES + 1);
	localparam int PB_W  = $clog2(PAGE_BYTES);
	localparam logic [ADDR_W:0]    POOL_BYTES = (ADDR_W+1)'(NUM_PAGES) << PB_W;
	localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(NUM_PAGES);
	localparam logic [REF_W-1:0]   REF_ONE    = REF_W'(1);

	// state
	logic [ADDR_W-1:0] base_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  free_q;
	logic [IDX_W-1:0]  link_mem [NUM_PAGES];
	logic [REF_W-1:0]  refs_mem [NUM_PAGES];

	// request captured at accept
	mode_t                     mode_s1;
	logic signed [DELTA_W-1:0] delta_s1;
	logic [REF_W-1:0]          cval_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic                      in_range_s1;
	logic                      aligned_s1;
	logic [IDX_W-1:0]          link_rd_s1;
	logic [REF_W-1:0]          ref_rd_s1;

	// result register
	logic [ADDR_W-1:0] page_addr_q;
	logic [REF_W-1:0]  ref_out_q;
	status_t           status_q;

	// decode and execute signals
	logic [ADDR_W:0]   diff;
	logic [IDX_W-1:0]  dec_idx;
	logic              dec_in_range;
	logic              dec_aligned;
	logic [IDX_W-1:0]  rd_addr;
	logic signed [REF_W+1:0] sum;
	logic [ADDR_W-1:0] page_addr_nx;
	logic [REF_W-1:0]  ref_out_nx;
	status_t           status_nx;
	logic [IDX_W-1:0]  head_nx;
	logic [CNT_W-1:0]  free_nx;
	logic              ref_we;
	logic [IDX_W-1:0]  ref_wa;
	logic [REF_W-1:0]  ref_wd;
	logic              link_we;
	logic [REF_W-1:0]  ref_dec;

	// address decode against the pool window
	assign diff         = {1'b0, address} - {1'b0, base_q};
	assign dec_in_range = !diff[ADDR_W] && ({1'b0, diff[ADDR_W-1:0]} < POOL_BYTES);
	assign dec_aligned  = (diff[PB_W-1:0] == '0);
	assign dec_idx      = diff[PB_W +: IDX_W];
	assign rd_addr      = (mode_t'(mode) == MODE_ALLOC) ? head_q : dec_idx;

	// pool base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			base_q <= BASE_RESET;
		else if (cfg_wr_en)
			base_q <= cfg_wr_data;
	end

	// request capture and memory read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_s1     <= mode_t'(mode);
			delta_s1    <= delta;
			cval_s1     <= count_value;
			idx_s1      <= dec_idx;
			in_range_s1 <= dec_in_range;
			aligned_s1  <= dec_aligned;
			link_rd_s1  <= link_mem[rd_addr];
			ref_rd_s1   <= refs_mem[rd_addr];
		end
	end

	// execute the captured request
	assign sum     = $signed({2'b00, ref_rd_s1}) + $signed({delta_s1[DELTA_W-1], delta_s1});
	assign ref_dec = ref_rd_s1 - 1'b1;

	always_comb begin
		page_addr_nx = '0;
		ref_out_nx   = '0;
		status_nx    = ST_OK;
		head_nx      = head_q;
		free_nx      = free_q;
		ref_we       = 1'b0;
		ref_wa       = idx_s1;
		ref_wd       = '0;
		link_we      = 1'b0;
		case (mode_s1)
			MODE_ALLOC: begin
				if (free_q == '0) begin
					status_nx = ST_NO_MEM;
				end else begin
					page_addr_nx = base_q + (ADDR_W'(head_q) << PB_W);
					ref_out_nx   = REF_ONE;
					ref_we       = 1'b1;
					ref_wa       = head_q;
					ref_wd       = REF_ONE;
					head_nx      = link_rd_s1;
					free_nx      = free_q - 1'b1;
				end
			end
			MODE_FREE: begin
				if (!(in_range_s1 && aligned_s1)) begin
					status_nx = ST_BAD_ADDR;
				end else if (free_q != '0 && idx_s1 == head_q) begin
					status_nx  = ST_HEAD_FREE;
					ref_out_nx = ref_rd_s1;
				end else if (ref_rd_s1 == '0) begin
					status_nx = ST_ZERO_FREE;
				end else begin
					ref_out_nx = ref_dec;
					ref_we     = 1'b1;
					ref_wd     = ref_dec;
					// last reference gone: push onto the list
					if (ref_dec == '0) begin
						link_we = 1'b1;
						head_nx = idx_s1;
						if (free_q < CNT_FULL)
							free_nx = free_q + 1'b1;
					end
				end
			end
			MODE_ADD: begin
				if (!in_range_s1) begin
					status_nx = ST_BAD_ADDR;
				end else if (sum > $signed({2'b00, REF_MAX})) begin
					status_nx  = ST_OVERFLOW;
					ref_out_nx = ref_rd_s1;
				end else if (sum < 0) begin
					status_nx  = ST_UNDERFLOW;
					ref_out_nx = ref_rd_s1;
				end else begin
					ref_out_nx = sum[REF_W-1:0];
					ref_we     = 1'b1;
					ref_wd     = sum[REF_W-1:0];
				end
			end
			MODE_SET: begin
				if (!in_range_s1) begin
					status_nx = ST_BAD_ADDR;
				end else begin
					ref_out_nx = cval_s1;
					ref_we     = 1'b1;
					ref_wd     = cval_s1;
				end
			end
			MODE_READ: begin
				if (!in_range_s1)
					status_nx = ST_BAD_ADDR;
				else
					ref_out_nx = ref_rd_s1;
			end
			default: begin
				status_nx = ST_IGNORED;
			end
		endcase
	end

	// list head and free counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= IDX_W'(NUM_PAGES - 1);
			free_q <= CNT_FULL;
		end else if (cmd.commit) begin
			head_q <= head_nx;
			free_q <= free_nx;
		end
	end

	// link memory: initialization sweep or push write
	always_ff @(posedge clk) begin
		if (cmd.clear)
			link_mem[clear_idx] <= (clear_idx == '0) ? '0 : clear_idx - 1'b1;
		else if (cmd.commit && link_we)
			link_mem[idx_s1] <= head_q;
	end

	// count memory: initialization sweep or count update
	always_ff @(posedge clk) begin
		if (cmd.clear)
			refs_mem[clear_idx] <= '0;
		else if (cmd.commit && ref_we)
			refs_mem[ref_wa] <= ref_wd;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			page_addr_q <= page_addr_nx;
			ref_out_q   <= ref_out_nx;
			status_q    <= status_nx;
		end
	end

	assign page_address = page_addr_q;
	assign ref_count    = ref_out_q;
	assign free_pages   = FREE_W'(free_q);
	assign status       = status_q;

endmodule

`default_nettype wire

@@ sv/page_allocator_with_ref_counts_core.sv @@
// ----------------------------------------------------------------------------
// page_allocator_with_ref_counts_core
// Page allocator with a LIFO free list and an 8-bit reference count per page.
//
//   channel | signals                                      | dir
//   --------+----------------------------------------------+-----
//   request | in_valid, in_ready, mode, address, delta,    | in
//           | count_value                                  |
//   result  | out_valid, out_ready, page_address,          | out
//           | ref_count, free_pages, status                |
//   config  | cfg_wr_en, cfg_wr_data (pool base address)   | in
//
// Each request is decoded, and the link and count memories are read, when it is
// accepted; in the execute state it writes them back and loads the result.
// After reset an initialization sweep writes the memories one entry a cycle,
// covering every entry, before the first request is taken.
// A stalled result holds the next request in the execute state until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module page_allocator_with_ref_counts_core #(
	parameter int NUM_PAGES  = pgalloc_pkg::DEF_NUM_PAGES,
	parameter int PAGE_BYTES = pgalloc_pkg::DEF_PAGE_BYTES
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [pgalloc_pkg::ADDR_W-1:0]         cfg_wr_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [pgalloc_pkg::MODE_W-1:0]         mode,
	input  wire logic [pgalloc_pkg::ADDR_W-1:0]         address,
	input  wire logic signed [pgalloc_pkg::DELTA_W-1:0] delta,
	input  wire logic [pgalloc_pkg::REF_W-1:0]          count_value,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [pgalloc_pkg::ADDR_W-1:0]              page_address,
	output logic [pgalloc_pkg::REF_W-1:0]               ref_count,
	output logic [pgalloc_pkg::FREE_W-1:0]              free_pages,
	output logic [pgalloc_pkg::STAT_W-1:0]              status
);
	import pgalloc_pkg::*;

	localparam int IDX_W = $clog2(NUM_PAGES);

	pga_cmd_t         cmd;
	logic [IDX_W-1:0] clear_idx;

	// sequencing
	pgalloc_ctrl #(
		.NUM_PAGES (NUM_PAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.clear_idx (clear_idx)
	);

	// storage and execution
	pgalloc_dp #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.clear_idx    (clear_idx),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.mode         (mode),
		.address      (address),
		.delta        (delta),
		.count_value  (count_value),
		.page_address (page_address),
		.ref_count    (ref_count),
		.free_pages   (free_pages),
		.status       (status)
	);

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page allocator core. A short table of requests
// hits the error codes and boundaries right after reset, then random traffic
// (normal mix, a pass that empties the free list, a release-heavy pass) runs
// under several pool base addresses and handshake idling patterns. Every
// result beat is compared with its table row or a software copy of the state.
// ----------------------------------------------------------------------------
module tb_top;
	import pgalloc_pkg::*;

	localparam int NUM_PAGES  = DEF_NUM_PAGES;
	localparam int PAGE_BYTES = DEF_PAGE_BYTES;
	localparam longint unsigned POOL_BYTES = longint'(NUM_PAGES) * PAGE_BYTES;
	localparam logic [ADDR_W-1:0] BASE_TOP  = 40'hFF_FFFF_F000;
	localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 4;
	localparam int HELD_MAX      = 48;
	localparam longint RUN_LIMIT_NS = 4_000_000;

	typedef enum int {MIX_NORMAL, MIX_FILL, MIX_RELEASE} traffic_mix_t;

	typedef struct {
		logic [MODE_W-1:0]         mode;
		logic [ADDR_W-1:0]         address;
		logic signed [DELTA_W-1:0] delta;
		logic [REF_W-1:0]          count_value;
	} page_req_t;

	typedef struct {
		logic [ADDR_W-1:0] page_address;
		logic [REF_W-1:0]  ref_count;
		logic [FREE_W-1:0] free_pages;
		status_t           status;
	} page_rsp_t;

	typedef struct {
		page_req_t req;
		bit        typed;
		page_rsp_t rsp;
	} dir_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [ADDR_W-1:0]          cfg_wr_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [MODE_W-1:0]          mode;
	logic [ADDR_W-1:0]          address;
	logic signed [DELTA_W-1:0]  delta;
	logic [REF_W-1:0]           count_value;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [ADDR_W-1:0]          page_address;
	logic [REF_W-1:0]           ref_count;
	logic [FREE_W-1:0]          free_pages;
	logic [STAT_W-1:0]          status;

	int unsigned send_idle_pct = 18;
	int unsigned recv_idle_pct = 83;
	int          err_count = 0;

	page_rsp_t   pending_rsp [$];
	dir_row_t    dir_rows [$];
	int unsigned held_pages [$];
	page_rsp_t   no_rsp;

	// allocator state as the bench sees it
	logic [ADDR_W-1:0] mdl_base;
	logic [FREE_W-1:0] mdl_head;
	logic [FREE_W-1:0] mdl_link [NUM_PAGES];
	logic [REF_W-1:0]  mdl_refs [NUM_PAGES];
	int unsigned       mdl_free;

	page_allocator_with_ref_counts_core #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.address      (address),
		.delta        (delta),
		.count_value  (count_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.page_address (page_address),
		.ref_count    (ref_count),
		.free_pages   (free_pages),
		.status       (status)
	);

	always #5 clk = ~clk;

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	function automatic void reset_model();
		mdl_base = BASE_RESET;
		mdl_head = FREE_W'(NUM_PAGES - 1);
		mdl_free = NUM_PAGES;
		for (int i = 0; i < NUM_PAGES; i++) begin
			mdl_link[i] = (i == 0) ? '0 : FREE_W'(i - 1);
			mdl_refs[i] = '0;
		end
	endfunction

	// byte address to page index, relative to the pool base
	function automatic bit locate_page(input logic [ADDR_W-1:0] addr, input bit aligned,
			output int unsigned idx);
		longint unsigned off;
		idx = 0;
		if (addr < mdl_base)
			return 1'b0;
		off = addr - mdl_base;
		if (off >= POOL_BYTES)
			return 1'b0;
		if (aligned && (off % PAGE_BYTES) != 0)
			return 1'b0;
		idx = int'(off / PAGE_BYTES);
		return 1'b1;
	endfunction

	// one request against the allocator state, returns the result beat
	function automatic page_rsp_t apply_request(input page_req_t r);
		page_rsp_t   o;
		int unsigned idx;
		int          sum;
		o.page_address = '0;
		o.ref_count    = '0;
		o.status       = ST_OK;
		idx = 0;
		case (r.mode) inside
			MODE_ALLOC: begin
				if (mdl_free == 0) begin
					o.status = ST_NO_MEM;
				end else begin
					idx = int'(mdl_head) % NUM_PAGES;
					o.page_address = mdl_base + ADDR_W'(longint'(idx) * PAGE_BYTES);
					mdl_refs[idx] = 8'd1;
					o.ref_count = 8'd1;
					mdl_head = mdl_link[idx];
					mdl_free--;
				end
			end
			MODE_FREE: begin
				if (!locate_page(r.address, 1'b1, idx)) begin
					o.status = ST_BAD_ADDR;
				end else if (mdl_free != 0 && idx == mdl_head) begin
					o.status = ST_HEAD_FREE;
					o.ref_count = mdl_refs[idx];
				end else if (mdl_refs[idx] == 0) begin
					o.status = ST_ZERO_FREE;
				end else begin
					mdl_refs[idx]--;
					o.ref_count = mdl_refs[idx];
					// last reference gone, page goes back on the list
					if (mdl_refs[idx] == 0) begin
						mdl_link[idx] = mdl_head;
						mdl_head = FREE_W'(idx);
						if (mdl_free < NUM_PAGES)
							mdl_free++;
					end
				end
			end
			MODE_ADD, MODE_SET, MODE_READ: begin
				if (!locate_page(r.address, 1'b0, idx)) begin
					o.status = ST_BAD_ADDR;
				end else if (r.mode == MODE_ADD) begin
					sum = int'(mdl_refs[idx]) + int'(r.delta);
					if (sum > int'(REF_MAX))
						o.status = ST_OVERFLOW;
					else if (sum < 0)
						o.status = ST_UNDERFLOW;
					else
						mdl_refs[idx] = REF_W'(sum);
					o.ref_count = mdl_refs[idx];
				end else if (r.mode == MODE_SET) begin
					mdl_refs[idx] = r.count_value;
					o.ref_count = r.count_value;
				end else begin
					o.ref_count = mdl_refs[idx];
				end
			end
			default: begin
				o.status = ST_IGNORED;
			end
		endcase
		o.free_pages = FREE_W'(mdl_free);
		return o;
	endfunction

	// page address under the reset base, for the table
	function automatic logic [ADDR_W-1:0] dpage(input int i);
		return BASE_RESET + ADDR_W'(longint'(i) * PAGE_BYTES);
	endfunction

	function automatic void stage_row(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
			input int d, input int c, input bit typed, input logic [ADDR_W-1:0] pa,
			input int rc, input int fp, input status_t st);
		dir_row_t row;
		row.req.mode         = m;
		row.req.address      = a;
		row.req.delta        = DELTA_W'(d);
		row.req.count_value  = REF_W'(c);
		row.typed            = typed;
		row.rsp.page_address = pa;
		row.rsp.ref_count    = REF_W'(rc);
		row.rsp.free_pages   = FREE_W'(fp);
		row.rsp.status       = st;
		dir_rows.push_back(row);
	endfunction

	// address mix: held pages, any page, misaligned, pool edges, junk
	function automatic logic [ADDR_W-1:0] pick_address(input bit for_free);
		int unsigned       roll;
		int unsigned       idx;
		logic [ADDR_W-1:0] a;
		roll = $urandom_range(99, 0);
		if (roll < 6)
			return ADDR_W'({$urandom(), $urandom()});
		if (roll < 10) begin
			case ($urandom_range(2, 0))
				0:       a = mdl_base - 1'b1;
				1:       a = mdl_base + ADDR_W'(POOL_BYTES);
				default: a = mdl_base + ADDR_W'(POOL_BYTES - 1);
			endcase
			return a;
		end
		if (held_pages.size() != 0 && roll < 65)
			idx = held_pages[$urandom_range(held_pages.size() - 1, 0)];
		else
			idx = $urandom_range(NUM_PAGES - 1, 0);
		a = mdl_base + ADDR_W'(longint'(idx) * PAGE_BYTES);
		if ($urandom_range(99, 0) < (for_free ? 8 : 25))
			a = a + ADDR_W'($urandom_range(PAGE_BYTES - 1, 1));
		return a;
	endfunction

	function automatic page_req_t gen_request(input traffic_mix_t mix);
		page_req_t   r;
		int unsigned roll;
		int unsigned cut [5];
		int          d;
		case (mix)
			MIX_FILL:    cut = '{95, 96, 97, 98, 99};
			MIX_RELEASE: cut = '{15, 65, 75, 85, 95};
			default:     cut = '{30, 62, 76, 84, 96};
		endcase
		roll = $urandom_range(99, 0);
		if (roll < cut[0])
			r.mode = MODE_ALLOC;
		else if (roll < cut[1])
			r.mode = MODE_FREE;
		else if (roll < cut[2])
			r.mode = MODE_ADD;
		else if (roll < cut[3])
			r.mode = MODE_SET;
		else if (roll < cut[4])
			r.mode = MODE_READ;
		else
			r.mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
		r.address = pick_address(r.mode == MODE_FREE);
		// small deltas keep counts moving, full range hits the limits
		if ($urandom_range(99, 0) < 60)
			d = int'($urandom_range(6, 0)) - 3;
		else
			d = int'($urandom_range(510, 0)) - 255;
		r.delta = DELTA_W'(d);
		roll = $urandom_range(99, 0);
		if (roll < 40)
			r.count_value = REF_W'($urandom_range(3, 1));
		else if (roll < 55)
			r.count_value = '0;
		else if (roll < 70)
			r.count_value = REF_MAX;
		else
			r.count_value = REF_W'($urandom_range(255, 0));
		return r;
	endfunction

	// present one request beat, record its expected result on acceptance
	task automatic send_request(input page_req_t r, input bit typed, input page_rsp_t typed_rsp);
		page_rsp_t         want;
		logic [ADDR_W-1:0] off;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= r.mode;
		address     <= r.address;
		delta       <= r.delta;
		count_value <= r.count_value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		want = apply_request(r);
		if (r.mode == MODE_ALLOC && want.status == ST_OK) begin
			off = want.page_address - mdl_base;
			held_pages.push_back(int'(off / PAGE_BYTES));
			if (held_pages.size() > HELD_MAX)
				void'(held_pages.pop_front());
		end
		if (typed)
			pending_rsp.push_back(typed_rsp);
		else
			pending_rsp.push_back(want);
	endtask

	// hold off requests until every result beat is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] v);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mdl_base = v;
	endtask

	task automatic check_result();
		page_rsp_t want;
		if (pending_rsp.size() == 0) begin
			$error("result beat with no request outstanding");
			err_count++;
			return;
		end
		want = pending_rsp.pop_front();
		if (page_address !== want.page_address) begin
			$error("page_address: expected %h, got %h", want.page_address, page_address);
			err_count++;
		end
		if (ref_count !== want.ref_count) begin
			$error("ref_count: expected %0d, got %0d", want.ref_count, ref_count);
			err_count++;
		end
		if (free_pages !== want.free_pages) begin
			$error("free_pages: expected %0d, got %0d", want.free_pages, free_pages);
			err_count++;
		end
		if (status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, status);
			err_count++;
		end
	endtask

	// result beats
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			check_result();
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		page_req_t         hreq;
		logic [ADDR_W-1:0] v;
		int unsigned       n;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		mode        <= '0;
		address     <= '0;
		delta       <= '0;
		count_value <= '0;
		reset_model();

		// error codes and edges from a fresh pool
		stage_row(MODE_READ, dpage(0), 0, 0, 1, '0, 0, 1024, ST_OK);
		stage_row(MODE_FREE, dpage(1023), 0, 0, 1, '0, 0, 1024, ST_HEAD_FREE);
		stage_row(MODE_FREE, dpage(0), 0, 0, 1, '0, 0, 1024, ST_ZERO_FREE);
		stage_row(MODE_FREE, dpage(0) + 1'b1, 0, 0, 1, '0, 0, 1024, ST_BAD_ADDR);
		stage_row(MODE_READ, BASE_RESET - 1'b1, 0, 0, 1, '0, 0, 1024, ST_BAD_ADDR);
		stage_row(MODE_READ, dpage(1024), 0, 0, 1, '0, 0, 1024, ST_BAD_ADDR);
		stage_row(MODE_READ, '0, 0, 0, 1, '0, 0, 1024, ST_BAD_ADDR);
		stage_row(MODE_SET, ADDR_ONES, 0, 255, 1, '0, 0, 1024, ST_BAD_ADDR);
		stage_row(MODE_ALLOC, ADDR_ONES, -255, 255, 1, dpage(1023), 1, 1023, ST_OK);
		stage_row(MODE_ALLOC, '0, 0, 0, 1, dpage(1022), 1, 1022, ST_OK);
		stage_row(MODE_ADD, dpage(1023), 255, 0, 1, '0, 1, 1022, ST_OVERFLOW);
		stage_row(MODE_ADD, dpage(1023), -255, 0, 1, '0, 1, 1022, ST_UNDERFLOW);
		stage_row(MODE_ADD, dpage(1023), 254, 0, 1, '0, 255, 1022, ST_OK);
		// the rest goes through the predictor
		stage_row(MODE_ADD, dpage(1023) + 12'hFFF, -1, 0, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_SET, dpage(1022) + 7'd123, 0, 255, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_SET, dpage(1022), 0, 0, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_FREE, dpage(1022), 0, 0, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_SET, dpage(1022), 0, 2, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_FREE, dpage(1022), 0, 0, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_FREE, dpage(1022), 0, 0, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_FREE, dpage(1022), 0, 0, 0, '0, 0, 0, ST_OK);
		// a page pushed twice, free count saturates
		stage_row(MODE_SET, dpage(0), 0, 1, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_FREE, dpage(0), 0, 0, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_SET, dpage(5), 0, 1, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_FREE, dpage(5), 0, 0, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_SPARE_LO, dpage(0), 0, 0, 0, '0, 0, 0, ST_OK);
		stage_row(MODE_SPARE_HI, ADDR_ONES, 255, 255, 0, '0, 0, 0, ST_OK);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// sender light, receiver heavy idling
		write_base(BASE_RESET);
		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
		write_base('0);
		repeat (40) send_request(gen_request(MIX_NORMAL), 1'b0, no_rsp);

		// idling swapped, run the free list dry
		send_idle_pct = 83;
		recv_idle_pct = 18;
		write_base(ADDR_W'({$urandom(), $urandom()}) & ~ADDR_W'(PAGE_BYTES - 1));
		n = 0;
		while (mdl_free != 0 && n < 2500) begin
			send_request(gen_request(MIX_FILL), 1'b0, no_rsp);
			n++;
		end
		hreq.mode        = MODE_ALLOC;
		hreq.address     = ADDR_ONES;
		hreq.delta       = '0;
		hreq.count_value = '0;
		send_request(hreq, 1'b0, no_rsp);
		// freeing the head is allowed once the list is empty
		hreq.mode    = MODE_FREE;
		hreq.address = mdl_base + ADDR_W'(longint'(mdl_head) * PAGE_BYTES);
		send_request(hreq, 1'b0, no_rsp);
		repeat (30) send_request(gen_request(MIX_NORMAL), 1'b0, no_rsp);

		// pool at the top of the address space, allocations wrap
		write_base(BASE_TOP);
		repeat (40) send_request(gen_request(MIX_NORMAL), 1'b0, no_rsp);

		// no idling, arbitrary base, one full drain partway through
		send_idle_pct = 0;
		recv_idle_pct = 0;
		v = ADDR_W'({$urandom(), $urandom()});
		if (v > BASE_TOP)
			v = v - ADDR_W'(PAGE_BYTES);
		write_base(v);
		for (int i = 0; i < 60; i++) begin
			if (i % 37 == 36)
				wait_drained();
			send_request(gen_request(MIX_NORMAL), 1'b0, no_rsp);
		end

		write_base(BASE_RESET);
		repeat (40) send_request(gen_request(MIX_RELEASE), 1'b0, no_rsp);

		wait_drained();
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ page_allocator_with_ref_counts_core.f @@
sv/pgalloc_pkg.sv
sv/pgalloc_ctrl.sv
sv/pgalloc_dp.sv
sv/page_allocator_with_ref_counts_core.sv
test/tb_top.sv
